>>> rtl/double_hash_key_value_table_top_assert.svh
// Assertion macros for the double-hashing key/value table.
// Used by double_hash_key_value_table_top; depends on nothing else.
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define DHKV_ASSERT_SAME(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DHKV_ASSERT_NEXT(label, clk, rstn, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/dhkv_pkg.sv
// Shared types and constants for the double-hashing key/value table.
// Depends on nothing; imported by double_hash_key_value_table_top.
`default_nettype none

package dhkv_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int CFG_W     = 11;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;

    localparam logic [6:0] HASH_MULT = 7'd101;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd3;

    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_LOAD_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd11;
    localparam logic [CFG_W-1:0] LOAD_LIMIT_RST = 11'd7;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
    } slot_entry_t;

endpackage

`default_nettype wire

>>> rtl/double_hash_key_value_table_top.sv
// Double-hashing open-addressed key/value table with a shared remainder unit.
// Depends on dhkv_pkg and double_hash_key_value_table_top_assert.svh.
//
// Usage: an operation transaction enters on in_valid/in_stall with operation,
// hash_code, key and value; exactly one result transaction leaves on
// out_valid/out_stall with found, value_out, status and entry_count.
// Configuration registers (table size, load limit) are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, as the block itself does not enforce it. One transaction is
// handled at a time. Lookup, insert and remove run a bit-serial remainder
// unit twice (start slot, probe step), then each probe is a memory read and
// a compare. A clear with entries present walks all DEPTH slots; other
// operations, and an insert refused at the load limit, go straight to the result.
// After reset the block runs a clearing pass over the whole slot memory
// with in_stall high; configuration writes are still taken.
// A finished result sits in the output register; while the receiver stalls,
// the next transaction can be taken but its result waits until the output
// register is free.
`default_nettype none

`include "double_hash_key_value_table_top_assert.svh"

module double_hash_key_value_table_top
    import dhkv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      operation,
    input  wire logic [WORD_W-1:0]    hash_code,
    input  wire logic [WORD_W-1:0]    key,
    input  wire logic [WORD_W-1:0]    value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      found,
    output logic [WORD_W-1:0]         value_out,
    output logic [STATUS_W-1:0]       status,
    output logic [COUNT_W-1:0]        entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_DIV2  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;
    slot_entry_t mem_wdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;

    logic [CFG_W-1:0] table_size_reg, load_limit_reg;
    logic [2:0] state_reg, state_next;
    logic       emit_reg, emit_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [WORD_W-1:0] h_reg, h_next, k_reg, k_next, v_reg, v_next;
    logic [SW-1:0] size_reg, size_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [SW-1:0] div_d_reg, div_d_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic [SW-1:0] slot_reg, slot_next, incr_reg, incr_next, n_reg, n_next;
    logic [COUNT_W-1:0] live_reg, live_next;
    logic [WORD_W-1:0] version_reg, version_next;
    logic res_found_reg, res_found_next;
    logic [WORD_W-1:0] res_vout_reg, res_vout_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic out_valid_reg;
    logic [WORD_W-1:0] out_vout_reg;
    logic out_found_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic in_acc, out_free;
    logic [31:0] ts_wide;
    logic [SW-1:0] eff_size;
    logic [SW:0] rem_shift;
    logic [SW-1:0] rem_step;
    logic [SW:0] slot_sum;
    logic [SW-1:0] slot_adv;
    logic [WORD_W-1:0] hash_mul;
    logic slot_match;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign value_out = out_vout_reg;
    assign status    = out_status_reg;
    assign entry_count = out_count_reg;

    always_comb
    begin
        ts_wide = 32'(table_size_reg);
        if (ts_wide < 32'd2)
        begin
            eff_size = SW'(2);
        end
        else if (ts_wide > 32'(DEPTH))
        begin
            eff_size = SW'(DEPTH);
        end
        else
        begin
            eff_size = SW'(ts_wide);
        end
    end

    assign rem_shift = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_step  = (rem_shift >= {1'b0, div_d_reg}) ?
                       SW'(rem_shift - {1'b0, div_d_reg}) : SW'(rem_shift);
    assign slot_sum  = {1'b0, slot_reg} + {1'b0, incr_reg};
    assign slot_adv  = (slot_sum >= {1'b0, size_reg}) ?
                       SW'(slot_sum - {1'b0, size_reg}) : SW'(slot_sum);
    assign hash_mul  = h_reg * {25'd0, HASH_MULT};
    assign slot_match = rd_data_reg.valid && (rd_data_reg.hash == h_reg)
                        && (rd_data_reg.key == k_reg);

    always_comb
    begin
        state_next = state_reg;
        emit_next = emit_reg;
        clr_next = clr_reg;
        op_next = op_reg;
        h_next = h_reg;
        k_next = k_reg;
        v_next = v_reg;
        size_next = size_reg;
        dvd_next = dvd_reg;
        div_d_next = div_d_reg;
        rem_next = rem_reg;
        div_cnt_next = div_cnt_reg;
        slot_next = slot_reg;
        incr_next = incr_reg;
        n_next = n_reg;
        live_next = live_reg;
        version_next = version_reg;
        res_found_next = res_found_reg;
        res_vout_next = res_vout_reg;
        res_status_next = res_status_reg;
        mem_we = 1'b0;
        mem_waddr = slot_reg[AW-1:0];
        mem_wdata.valid = 1'b1;
        mem_wdata.hash = h_reg;
        mem_wdata.key = k_reg;
        mem_wdata.value = v_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = operation;
                    h_next = hash_code;
                    k_next = key;
                    v_next = value;
                    size_next = eff_size;
                    res_found_next = 1'b0;
                    res_vout_next = '0;
                    res_status_next = ST_OK;
                    dvd_next = hash_code;
                    div_d_next = eff_size;
                    rem_next = '0;
                    div_cnt_next = '0;
                    state_next = S_DONE;
                    if (operation == OP_CLEAR)
                    begin
                        if (live_reg != '0)
                        begin
                            live_next = '0;
                            version_next = version_reg + 32'd1;
                            clr_next = '0;
                            emit_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                    end
                    else if (operation == OP_ADD || operation == OP_SET)
                    begin
                        if (live_reg >= load_limit_reg)
                        begin
                            res_status_next = ST_LIMIT;
                        end
                        else
                        begin
                            state_next = S_DIV1;
                        end
                    end
                    else if (operation == OP_LOOKUP || operation == OP_REMOVE)
                    begin
                        state_next = S_DIV1;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata.valid = 1'b0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = emit_reg ? S_DONE : S_IDLE;
                end
            end
            S_DIV1:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    slot_next = rem_step;
                    dvd_next = hash_mul;
                    div_d_next = size_reg - SW'(1);
                    rem_next = '0;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    incr_next = rem_step + SW'(1);
                    n_next = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_RD;
                if (op_reg == OP_LOOKUP || op_reg == OP_REMOVE)
                begin
                    if (slot_match)
                    begin
                        res_found_next = 1'b1;
                        state_next = S_DONE;
                        if (op_reg == OP_LOOKUP)
                        begin
                            res_vout_next = rd_data_reg.value;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wdata.valid = 1'b0;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - COUNT_W'(1);
                            end
                            version_next = version_reg + 32'd1;
                        end
                    end
                end
                else if (!rd_data_reg.valid)
                begin
                    mem_we = 1'b1;
                    live_next = live_reg + COUNT_W'(1);
                    version_next = version_reg + 32'd1;
                    state_next = S_DONE;
                end
                else if (slot_match)
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_ADD)
                    begin
                        res_status_next = ST_DUP;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        version_next = version_reg + 32'd1;
                    end
                end
                if (state_next == S_RD)
                begin
                    slot_next = slot_adv;
                    n_next = n_reg + SW'(1);
                    if (n_reg == size_reg - SW'(1))
                    begin
                        state_next = S_DONE;
                        if (op_reg == OP_ADD || op_reg == OP_SET)
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[slot_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
            load_limit_reg <= LOAD_LIMIT_RST;
            state_reg <= S_CLEAR;
            emit_reg <= 1'b0;
            clr_reg <= '0;
            live_reg <= '0;
            version_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TABLE_SIZE)
                begin
                    table_size_reg <= cfg_data;
                end
                else
                begin
                    load_limit_reg <= cfg_data;
                end
            end
            state_reg <= state_next;
            emit_reg <= emit_next;
            clr_reg <= clr_next;
            live_reg <= live_next;
            version_reg <= version_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        h_reg <= h_next;
        k_reg <= k_next;
        v_reg <= v_next;
        size_reg <= size_next;
        dvd_reg <= dvd_next;
        div_d_reg <= div_d_next;
        rem_reg <= rem_next;
        div_cnt_reg <= div_cnt_next;
        slot_reg <= slot_next;
        incr_reg <= incr_next;
        n_reg <= n_next;
        res_found_reg <= res_found_next;
        res_vout_reg <= res_vout_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_found_reg <= res_found_reg;
            out_vout_reg <= res_vout_reg;
            out_status_reg <= res_status_reg;
            out_count_reg <= live_reg;
        end
    end

    `DHKV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall, "accepted transaction did not make the block busy")
    `DHKV_ASSERT_SAME(a_divisor_nonzero, clk, rst_n, (state_reg == S_DIV1) || (state_reg == S_DIV2), div_d_reg != '0, "remainder unit divisor is zero")
    `DHKV_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, 32'(live_reg) <= 32'(DEPTH), "entry count exceeds depth")

endmodule

`default_nettype wire
